@@ hdl/interrupt_vector_router_core_defines.svh @@
// assertion macros for the interrupt vector router checker
// expects clk and rst in the scope where a macro is used
`ifndef INTERRUPT_VECTOR_ROUTER_CORE_DEFINES_SVH
`define INTERRUPT_VECTOR_ROUTER_CORE_DEFINES_SVH

// consequence holds in the same cycle
`define IVR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interrupt vector router check failed");

// consequence holds in the cycle after the antecedent
`define IVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interrupt vector router check failed");

// consequence holds in the cycle after a reset cycle
`define IVR_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("interrupt vector router reset check failed");

`endif

@@ hdl/ivr_pkg.sv @@
// shared types and constants of the interrupt vector router
// used by ivr_ctrl, ivr_dpath, the core and the checker
package ivr_pkg;

  localparam logic [2:0] CMD_ATTACH   = 3'd0;
  localparam logic [2:0] CMD_DETACH   = 3'd1;
  localparam logic [2:0] CMD_DISPATCH = 3'd2;
  localparam logic [2:0] CMD_ENTER    = 3'd3;
  localparam logic [2:0] CMD_EXIT     = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_VECTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IPI_VECTOR  = 1'd1;
  localparam logic [7:0] TICK_VECTOR_RESET = 8'd0;
  localparam logic [7:0] IPI_VECTOR_RESET  = 8'd1;

  localparam int OUT_CAP = 16;
  localparam int CNT_W   = 4;

  localparam logic [2:0] K_SINGLE      = 3'd0;
  localparam logic [2:0] K_ATTACH_TICK = 3'd1;
  localparam logic [2:0] K_ATTACH_MAP  = 3'd2;
  localparam logic [2:0] K_DETACH      = 3'd3;
  localparam logic [2:0] K_DISP_TICK   = 3'd4;
  localparam logic [2:0] K_DISP_MAP    = 3'd5;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] vector;
    logic [3:0] vcpu_id;
  } ivr_req_t;

  typedef struct packed {
    logic [3:0] target_vcpu;
    logic       deliver;
    logic       ipi;
    logic       status;
    logic [4:0] nesting_depth;
    logic       reschedule;
    logic       last;
  } ivr_rsp_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic slot_step;
    logic attach_commit;
    logic attach_map;
    logic detach_start;
    logic sweep_rd;
    logic map_read;
    logic nest_update;
    logic fan_step;
    logic emit_single;
  } ivr_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       mem_last;
    logic       slot_last;
    logic       out_free;
    logic       fan_last;
  } ivr_stat_t;

endpackage

@@ hdl/ivr_ctrl.sv @@
// controller state machine of the interrupt vector router
// depends on ivr_pkg; drives ivr_dpath through command and status structs
module ivr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  ivr_pkg::ivr_stat_t stat,
  output ivr_pkg::ivr_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_ASCAN  = 4'd3;
  localparam logic [3:0] S_AFIN   = 4'd4;
  localparam logic [3:0] S_DREAD  = 4'd5;
  localparam logic [3:0] S_DTAIL  = 4'd6;
  localparam logic [3:0] S_FSCAN  = 4'd7;
  localparam logic [3:0] S_RESULT = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.mem_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          ivr_pkg::K_ATTACH_TICK: state_next = S_ASCAN;
          ivr_pkg::K_ATTACH_MAP: begin
            cmd.attach_map = 1'b1;
            state_next     = S_RESULT;
          end
          ivr_pkg::K_DETACH: begin
            cmd.detach_start = 1'b1;
            state_next       = S_DREAD;
          end
          ivr_pkg::K_DISP_TICK: state_next = S_FSCAN;
          ivr_pkg::K_DISP_MAP: begin
            cmd.map_read = 1'b1;
            state_next   = S_RESULT;
          end
          default: begin
            cmd.nest_update = 1'b1;
            state_next      = S_RESULT;
          end
        endcase
      end
      S_ASCAN: begin
        cmd.slot_step = 1'b1;
        if (stat.slot_last) state_next = S_AFIN;
      end
      S_AFIN: begin
        cmd.attach_commit = 1'b1;
        state_next        = S_RESULT;
      end
      S_DREAD: begin
        cmd.sweep_rd = 1'b1;
        if (stat.mem_last) state_next = S_DTAIL;
      end
      S_DTAIL: state_next = S_RESULT;
      S_FSCAN: begin
        if (stat.out_free) begin
          cmd.fan_step = 1'b1;
          if (stat.fan_last) state_next = S_IDLE;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/ivr_dpath.sv @@
// datapath of the interrupt vector router: owner memory, tick slots,
// nesting counter, config registers and result register; depends on ivr_pkg
module ivr_dpath #(
  parameter int NUM_VECTORS = 256,
  parameter int NUM_VCPUS   = 16,
  parameter int MAX_NESTING = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ivr_pkg::ivr_req_t                req,
  input  logic                             cfg_we,
  input  logic [ivr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  ivr_pkg::ivr_cmd_t                cmd,
  output ivr_pkg::ivr_stat_t               stat,
  input  logic                             rsp_stall,
  output logic                             rsp_valid,
  output ivr_pkg::ivr_rsp_t                rsp
);

  localparam int AW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam int SW = (NUM_VCPUS > 1) ? $clog2(NUM_VCPUS) : 1;
  localparam int NW = $clog2(MAX_NESTING + 1);

  logic [7:0] tick_vector, ipi_vector;
  logic [2:0] item_cmd;
  logic [7:0] item_vec;
  logic [3:0] item_id;

  logic [NUM_VCPUS-1:0] slot_valid;
  logic [3:0]           slot_id [NUM_VCPUS];
  logic [SW-1:0]        sidx, fe_idx;
  logic                 present, have_empty, full;
  logic [ivr_pkg::CNT_W-1:0] fan_cnt;
  logic [NW-1:0]        nest;

  // owner entry: valid in bit 4, vcpu id below
  logic [4:0]    owner_mem [NUM_VECTORS];
  logic [4:0]    rd_q;
  logic [AW-1:0] maddr, rd_addr_q, rd_addr, vaddr;
  logic          rd_pend, rd_en;

  logic is_tick, is_ipi, in_range, map_hit, more_above, sweep_hit, fan_last, slot_fill;
  logic out_valid, load_out;
  ivr_pkg::ivr_rsp_t rsp_q, rsp_next;
  logic [2:0] kind;

  assign is_tick   = (item_vec == tick_vector);
  assign is_ipi    = (item_vec == ipi_vector);
  assign in_range  = (32'(item_vec) < NUM_VECTORS);
  assign vaddr     = AW'(item_vec);
  assign map_hit   = (item_cmd == ivr_pkg::CMD_DISPATCH) && !is_ipi && !is_tick
                     && in_range && rd_q[4];
  assign sweep_hit = rd_pend && rd_q[4] && (rd_q[3:0] == item_id);
  assign slot_fill = cmd.attach_commit && !present && have_empty;

  always_comb begin
    case (item_cmd)
      ivr_pkg::CMD_ATTACH: kind = is_tick ? ivr_pkg::K_ATTACH_TICK : ivr_pkg::K_ATTACH_MAP;
      ivr_pkg::CMD_DETACH: kind = ivr_pkg::K_DETACH;
      ivr_pkg::CMD_DISPATCH: begin
        if (is_ipi) kind = ivr_pkg::K_SINGLE;
        else if (is_tick) kind = (|slot_valid) ? ivr_pkg::K_DISP_TICK : ivr_pkg::K_SINGLE;
        else kind = ivr_pkg::K_DISP_MAP;
      end
      default: kind = ivr_pkg::K_SINGLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_vector <= ivr_pkg::TICK_VECTOR_RESET;
      ipi_vector  <= ivr_pkg::IPI_VECTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ivr_pkg::REG_TICK_VECTOR: tick_vector <= cfg_wdata;
        ivr_pkg::REG_IPI_VECTOR:  ipi_vector  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd <= req.command;
      item_vec <= req.vector;
      item_id  <= req.vcpu_id;
    end
  end

  // tick subscriber slots
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (slot_fill) slot_valid[fe_idx] <= 1'b1;
      if (cmd.detach_start) begin
        for (int i = 0; i < NUM_VCPUS; i++) begin
          if (slot_valid[i] && slot_id[i] == item_id) slot_valid[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_fill) slot_id[fe_idx] <= item_id;
  end

  // slot walk for tick attach and fan-out
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sidx       <= '0;
      fe_idx     <= '0;
      present    <= 1'b0;
      have_empty <= 1'b0;
      full       <= 1'b0;
      fan_cnt    <= '0;
    end else begin
      if (cmd.slot_step) begin
        if (slot_valid[sidx] && slot_id[sidx] == item_id) present <= 1'b1;
        if (!slot_valid[sidx] && !have_empty) begin
          have_empty <= 1'b1;
          fe_idx     <= sidx;
        end
        sidx <= sidx + 1'b1;
      end
      if (cmd.attach_commit && !present && !have_empty) full <= 1'b1;
      if (cmd.fan_step) begin
        if (slot_valid[sidx]) fan_cnt <= fan_cnt + 1'b1;
        sidx <= sidx + 1'b1;
      end
    end
  end

  always_comb begin
    more_above = 1'b0;
    for (int i = 0; i < NUM_VCPUS; i++) begin
      if (i > int'(sidx) && slot_valid[i]) more_above = 1'b1;
    end
  end

  assign fan_last = slot_valid[sidx]
                    && (!more_above || fan_cnt == ivr_pkg::CNT_W'(ivr_pkg::OUT_CAP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      nest <= '0;
    end else if (cmd.nest_update) begin
      if (item_cmd == ivr_pkg::CMD_ENTER && nest < NW'(MAX_NESTING)) begin
        nest <= nest + 1'b1;
      end else if (item_cmd == ivr_pkg::CMD_EXIT && nest != '0) begin
        nest <= nest - 1'b1;
      end
    end
  end

  // owner memory with clearing pass and detach sweep
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      maddr <= '0;
    end else if (cmd.clr_step || cmd.sweep_rd) begin
      maddr <= maddr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.sweep_rd;
    end
    rd_addr_q <= maddr;
  end

  assign rd_addr = cmd.sweep_rd ? maddr : vaddr;
  assign rd_en   = cmd.sweep_rd || cmd.map_read;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      owner_mem[maddr] <= '0;
    end else if (cmd.attach_map && in_range) begin
      owner_mem[vaddr] <= {1'b1, item_id};
    end else if (sweep_hit) begin
      owner_mem[rd_addr_q] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= owner_mem[rd_addr];
  end

  // result register
  assign load_out = cmd.emit_single || (cmd.fan_step && slot_valid[sidx]);

  always_comb begin
    rsp_next               = '0;
    rsp_next.nesting_depth = 5'(nest);
    if (cmd.fan_step) begin
      rsp_next.target_vcpu = slot_id[sidx];
      rsp_next.deliver     = 1'b1;
      rsp_next.last        = fan_last;
    end else begin
      rsp_next.target_vcpu = map_hit ? rd_q[3:0] : 4'd0;
      rsp_next.deliver     = map_hit;
      rsp_next.ipi         = (item_cmd == ivr_pkg::CMD_DISPATCH) && is_ipi;
      rsp_next.status      = full;
      rsp_next.reschedule  = (item_cmd == ivr_pkg::CMD_EXIT) && (nest == '0);
      rsp_next.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) rsp_q <= rsp_next;
  end

  assign rsp_valid = out_valid;
  assign rsp       = rsp_q;

  assign stat.kind      = kind;
  assign stat.mem_last  = (maddr == AW'(NUM_VECTORS - 1));
  assign stat.slot_last = (sidx == SW'(NUM_VCPUS - 1));
  assign stat.out_free  = !out_valid || !rsp_stall;
  assign stat.fan_last  = fan_last;

endmodule

@@ hdl/interrupt_vector_router_core.sv @@
// interrupt vector router top level: routes vectors to virtual cpus
// depends on ivr_pkg, ivr_ctrl and ivr_dpath
//
// req carries one command (attach, detach, dispatch, enter, exit) with a
// vector and a vcpu id; it transfers when req_valid is high and req_stall low.
// rsp carries result items; the last item of a command has last set. the cfg
// port writes tick_vector (index 0) and ipi_vector (index 1); the user must
// write them only while idle, the block itself does not enforce it.
// one item at a time: a command is taken in idle, decoded in the next cycle.
// single-result commands end in the result state, which loads the result
// register. tick attach first walks the slots; detach first sweeps the owner
// memory one entry a cycle through its single read port. tick dispatch fans
// out one slot a cycle while the result register is free, at most 16 results.
// after reset a clearing pass writes every owner entry invalid with req_stall
// high; cfg writes are taken meanwhile.
// a stalled result holds in the result register and the work waits on it.
module interrupt_vector_router_core #(
  parameter int NUM_VECTORS = 256,
  parameter int NUM_VCPUS   = 16,
  parameter int MAX_NESTING = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  ivr_pkg::ivr_req_t             req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output ivr_pkg::ivr_rsp_t             rsp,
  input  logic                          cfg_we,
  input  logic [ivr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);

  ivr_pkg::ivr_cmd_t  cmd;
  ivr_pkg::ivr_stat_t stat;

  ivr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ivr_dpath #(
    .NUM_VECTORS (NUM_VECTORS),
    .NUM_VCPUS   (NUM_VCPUS),
    .MAX_NESTING (MAX_NESTING)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

@@ hdl/ivr_check.sv @@
// port checker of the interrupt vector router and its bind to the core
// depends on ivr_pkg and interrupt_vector_router_core_defines.svh
`include "interrupt_vector_router_core_defines.svh"

module ivr_check (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input ivr_pkg::ivr_rsp_t rsp
);

  `IVR_ASSERT_RESET(a_reset_quiet, req_stall && !rsp_valid)
  `IVR_ASSERT_NEXT(a_req_one_at_a_time, req_valid && !req_stall, req_stall)
  `IVR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `IVR_ASSERT_SAME(a_fanout_blocks_req, rsp_valid && !rsp.last, req_stall)

endmodule

bind interrupt_vector_router_core ivr_check u_ivr_check (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench of interrupt_vector_router_core: directed table, then random traffic
// runs a routing predictor of its own; depends on ivr_pkg and the core rtl
module testbench;

  localparam int NUM_VECTORS   = 256;
  localparam int NUM_VCPUS     = 16;
  localparam int MAX_NESTING   = 16;
  localparam int NUM_DIRECTED  = 25;
  localparam int NUM_PHASES    = 4;
  localparam int PHASE_ITEMS   = 46;
  localparam int SETTLE_CYCLES = NUM_VECTORS + 2 * NUM_VCPUS + 16;
  localparam int HOLD_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [2:0] CMD_RSVD_MID = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

  typedef struct packed {
    ivr_pkg::ivr_req_t req;
    logic              typed;
    ivr_pkg::ivr_rsp_t rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  ivr_pkg::ivr_req_t req;
  logic rsp_valid;
  logic rsp_stall;
  ivr_pkg::ivr_rsp_t rsp;
  logic cfg_we;
  logic [ivr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  logic       owner_valid [NUM_VECTORS];
  logic [3:0] owner_id [NUM_VECTORS];
  logic       slot_valid [NUM_VCPUS];
  logic [3:0] slot_id [NUM_VCPUS];
  logic [4:0] depth;
  logic [7:0] tick_vec;
  logic [7:0] ipi_vec;
  logic [7:0] vec_pool [4];

  ivr_pkg::ivr_rsp_t pending_results [$];
  ivr_pkg::ivr_rsp_t expected_now;
  ivr_pkg::ivr_rsp_t typed_result;
  bit use_typed;
  bit quiet;
  bit hold_request;
  int hold_left;
  int error_count;
  int cycle_count;

  interrupt_vector_router_core #(
    .NUM_VECTORS(NUM_VECTORS),
    .NUM_VCPUS(NUM_VCPUS),
    .MAX_NESTING(MAX_NESTING)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ivr_pkg::ivr_rsp_t make_result(logic [3:0] tgt, logic dl, logic ip,
                                                    logic st, logic [4:0] dep, logic rs,
                                                    logic lst);
    ivr_pkg::ivr_rsp_t res;
    res.target_vcpu   = tgt;
    res.deliver       = dl;
    res.ipi           = ip;
    res.status        = st;
    res.nesting_depth = dep;
    res.reschedule    = rs;
    res.last          = lst;
    return res;
  endfunction

  function automatic stim_row_t plain_row(logic [2:0] cmd, logic [7:0] vec, logic [3:0] id);
    stim_row_t row;
    row.req.command = cmd;
    row.req.vector  = vec;
    row.req.vcpu_id = id;
    row.typed       = 1'b0;
    row.rsp         = '0;
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [2:0] cmd, logic [7:0] vec, logic [3:0] id,
                                          logic ip, logic [4:0] dep, logic rs);
    stim_row_t row;
    row       = plain_row(cmd, vec, id);
    row.typed = 1'b1;
    row.rsp   = make_result(4'd0, 1'b0, ip, 1'b0, dep, rs, 1'b1);
    return row;
  endfunction

  // routing predictor: updates the tables and queues the results of one command
  function automatic void route_command(ivr_pkg::ivr_req_t r);
    logic present;
    logic placed;
    logic st;
    logic ip;
    logic rs;
    logic dl;
    logic [3:0] tgt;
    int occupied;
    int k;
    int i;
    st = 1'b0;
    ip = 1'b0;
    rs = 1'b0;
    dl = 1'b0;
    tgt = 4'd0;
    occupied = 0;
    case (r.command)
      ivr_pkg::CMD_ATTACH: begin
        if (r.vector == tick_vec) begin
          present = 1'b0;
          for (i = 0; i < NUM_VCPUS; i++)
            if (slot_valid[i] && slot_id[i] == r.vcpu_id) present = 1'b1;
          if (!present) begin
            placed = 1'b0;
            for (i = 0; i < NUM_VCPUS; i++) begin
              if (!placed && !slot_valid[i]) begin
                slot_valid[i] = 1'b1;
                slot_id[i] = r.vcpu_id;
                placed = 1'b1;
              end
            end
            st = !placed;
          end
        end else if (r.vector < NUM_VECTORS) begin
          owner_valid[r.vector] = 1'b1;
          owner_id[r.vector] = r.vcpu_id;
        end
      end
      ivr_pkg::CMD_DETACH: begin
        for (i = 0; i < NUM_VECTORS; i++)
          if (owner_valid[i] && owner_id[i] == r.vcpu_id) owner_valid[i] = 1'b0;
        for (i = 0; i < NUM_VCPUS; i++)
          if (slot_valid[i] && slot_id[i] == r.vcpu_id) slot_valid[i] = 1'b0;
      end
      ivr_pkg::CMD_DISPATCH: begin
        if (r.vector == ipi_vec) begin
          ip = 1'b1;
        end else if (r.vector == tick_vec) begin
          for (i = 0; i < NUM_VCPUS; i++)
            if (slot_valid[i]) occupied++;
          if (occupied > ivr_pkg::OUT_CAP) occupied = ivr_pkg::OUT_CAP;
          k = 0;
          for (i = 0; i < NUM_VCPUS; i++) begin
            if (slot_valid[i] && k < occupied) begin
              pending_results.push_back(make_result(slot_id[i], 1'b1, 1'b0, 1'b0, depth, 1'b0,
                                                    k == occupied - 1));
              k++;
            end
          end
        end else if (r.vector < NUM_VECTORS && owner_valid[r.vector]) begin
          dl = 1'b1;
          tgt = owner_id[r.vector];
        end
      end
      ivr_pkg::CMD_ENTER: begin
        if (depth < MAX_NESTING) depth = depth + 5'd1;
      end
      ivr_pkg::CMD_EXIT: begin
        if (depth > 0) depth = depth - 5'd1;
        rs = (depth == 0);
      end
      default: ;
    endcase
    if (occupied == 0)
      pending_results.push_back(make_result(tgt, dl, ip, st, depth, rs, 1'b1));
  endfunction

  function automatic void check_field(string name, logic [4:0] want, logic [4:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [7:0] pick_vector();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return tick_vec;
    if (r < 4) return ipi_vec;
    if (r < 8) return vec_pool[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic ivr_pkg::ivr_req_t random_command();
    ivr_pkg::ivr_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) r.command = ivr_pkg::CMD_ATTACH;
    else if (roll < 62) r.command = ivr_pkg::CMD_DISPATCH;
    else if (roll < 70) r.command = ivr_pkg::CMD_DETACH;
    else if (roll < 84) r.command = ivr_pkg::CMD_ENTER;
    else if (roll < 97) r.command = ivr_pkg::CMD_EXIT;
    else r.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    r.vector  = pick_vector();
    r.vcpu_id = 4'($urandom_range(0, 15));
    return r;
  endfunction

  task automatic offer(logic [2:0] cmd, logic [7:0] vec, logic [3:0] id);
    while (!quiet && $urandom_range(0, 99) < 18) begin
      req_valid <= 1'b0;
      req <= 15'($urandom);
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= {cmd, vec, id};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(logic [7:0] tick, logic [7:0] ipi);
    cfg_we <= 1'b1;
    cfg_index <= ivr_pkg::REG_TICK_VECTOR;
    cfg_wdata <= tick;
    @(negedge clk);
    cfg_index <= ivr_pkg::REG_IPI_VECTOR;
    cfg_wdata <= ipi;
    @(negedge clk);
    cfg_we <= 1'b0;
    tick_vec = tick;
    ipi_vec = ipi;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        route_command(req);
        if (use_typed) begin
          expected_now = pending_results.pop_back();
          pending_results.push_back(typed_result);
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no pending expectation");
          error_count++;
        end else begin
          expected_now = pending_results.pop_front();
          check_field("target_vcpu", 5'(expected_now.target_vcpu), 5'(rsp.target_vcpu));
          check_field("deliver", 5'(expected_now.deliver), 5'(rsp.deliver));
          check_field("ipi", 5'(expected_now.ipi), 5'(rsp.ipi));
          check_field("status", 5'(expected_now.status), 5'(rsp.status));
          check_field("nesting_depth", expected_now.nesting_depth, rsp.nesting_depth);
          check_field("reschedule", 5'(expected_now.reschedule), 5'(rsp.reschedule));
          check_field("last", 5'(expected_now.last), 5'(rsp.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !quiet && $urandom_range(0, 99) < 18;
      end
    end
  end

  initial begin
    stim_row_t         directed_rows [NUM_DIRECTED];
    logic [7:0]        phase_tick [NUM_PHASES];
    logic [7:0]        phase_ipi [NUM_PHASES];
    ivr_pkg::ivr_req_t r;
    logic [7:0]        v;
    logic [3:0]        id;
    int k;
    int ph;
    int sent;
    int roll;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = ivr_pkg::REG_TICK_VECTOR;
    cfg_wdata = 8'd0;
    quiet = 1'b0;
    use_typed = 1'b0;
    hold_request = 1'b0;
    error_count = 0;
    cycle_count = 0;
    for (k = 0; k < NUM_VECTORS; k++) owner_valid[k] = 1'b0;
    for (k = 0; k < NUM_VECTORS; k++) owner_id[k] = 4'd0;
    for (k = 0; k < NUM_VCPUS; k++) slot_valid[k] = 1'b0;
    for (k = 0; k < NUM_VCPUS; k++) slot_id[k] = 4'd0;
    depth = 5'd0;
    tick_vec = ivr_pkg::TICK_VECTOR_RESET;
    ipi_vec = ivr_pkg::IPI_VECTOR_RESET;

    // reset config: tick vector 0, ipi vector 1
    directed_rows[0]  = typed_row(ivr_pkg::CMD_ENTER, 8'd0, 4'd0, 1'b0, 5'd1, 1'b0);
    directed_rows[1]  = typed_row(ivr_pkg::CMD_EXIT, 8'd0, 4'd0, 1'b0, 5'd0, 1'b1);
    directed_rows[2]  = typed_row(ivr_pkg::CMD_EXIT, 8'd255, 4'd15, 1'b0, 5'd0, 1'b1);
    directed_rows[3]  = typed_row(ivr_pkg::CMD_DISPATCH, 8'd1, 4'd0, 1'b1, 5'd0, 1'b0);
    directed_rows[4]  = typed_row(ivr_pkg::CMD_DISPATCH, 8'd255, 4'd0, 1'b0, 5'd0, 1'b0);
    directed_rows[5]  = typed_row(ivr_pkg::CMD_DISPATCH, 8'd0, 4'd15, 1'b0, 5'd0, 1'b0);
    directed_rows[6]  = typed_row(CMD_RSVD_HI, 8'd255, 4'd15, 1'b0, 5'd0, 1'b0);
    directed_rows[7]  = plain_row(CMD_RSVD_LO, 8'd170, 4'd10);
    directed_rows[8]  = plain_row(CMD_RSVD_MID, 8'd85, 4'd5);
    directed_rows[9]  = plain_row(ivr_pkg::CMD_ATTACH, 8'd255, 4'd15);
    directed_rows[10] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd255, 4'd0);
    directed_rows[11] = plain_row(ivr_pkg::CMD_ATTACH, 8'd0, 4'd0);
    directed_rows[12] = plain_row(ivr_pkg::CMD_ATTACH, 8'd0, 4'd15);
    directed_rows[13] = plain_row(ivr_pkg::CMD_ATTACH, 8'd0, 4'd3);
    directed_rows[14] = plain_row(ivr_pkg::CMD_ATTACH, 8'd0, 4'd15);
    directed_rows[15] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd0, 4'd0);
    directed_rows[16] = plain_row(ivr_pkg::CMD_ATTACH, 8'd1, 4'd7);
    directed_rows[17] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd1, 4'd0);
    directed_rows[18] = plain_row(ivr_pkg::CMD_DETACH, 8'd0, 4'd15);
    directed_rows[19] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd255, 4'd0);
    directed_rows[20] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd0, 4'd0);
    directed_rows[21] = plain_row(ivr_pkg::CMD_ATTACH, 8'd0, 4'd9);
    directed_rows[22] = plain_row(ivr_pkg::CMD_DISPATCH, 8'd0, 4'd0);
    directed_rows[23] = plain_row(ivr_pkg::CMD_ENTER, 8'd128, 4'd8);
    directed_rows[24] = plain_row(ivr_pkg::CMD_EXIT, 8'd127, 4'd7);

    phase_tick[0] = 8'd255;  phase_ipi[0] = 8'd0;
    phase_tick[1] = 8'd37;   phase_ipi[1] = 8'd37;
    phase_tick[2] = 8'd200;  phase_ipi[2] = 8'd255;
    phase_tick[3] = 8'($urandom_range(0, 255));
    phase_ipi[3]  = 8'($urandom_range(0, 255));

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      use_typed = directed_rows[k].typed;
      typed_result = directed_rows[k].rsp;
      offer(directed_rows[k].req.command, directed_rows[k].req.vector,
            directed_rows[k].req.vcpu_id);
    end
    use_typed = 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      write_config(phase_tick[ph], phase_ipi[ph]);
      for (k = 0; k < 4; k++) vec_pool[k] = 8'($urandom_range(0, 255));
      quiet = (ph == 2);
      if (ph == 1) hold_request = 1'b1;
      sent = 0;
      if (ph == 0) begin
        // drive the depth into saturation and back down, with extra exits at zero
        for (k = 0; k < MAX_NESTING + 2; k++)
          offer(ivr_pkg::CMD_ENTER, 8'($urandom), 4'($urandom));
        for (k = 0; k < MAX_NESTING + 2; k++)
          offer(ivr_pkg::CMD_EXIT, 8'($urandom), 4'($urandom));
        sent = 2 * (MAX_NESTING + 2);
      end
      while (sent < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        id = 4'($urandom_range(0, 15));
        if (roll < 55) begin
          r = random_command();
          offer(r.command, r.vector, r.vcpu_id);
          sent += 1;
        end else if (roll < 80) begin
          v = pick_vector();
          offer(ivr_pkg::CMD_ATTACH, v, id);
          offer(ivr_pkg::CMD_DISPATCH, v, 4'($urandom));
          sent += 2;
        end else if (roll < 92) begin
          offer(ivr_pkg::CMD_ATTACH, tick_vec, id);
          offer(ivr_pkg::CMD_DISPATCH, tick_vec, 4'($urandom));
          sent += 2;
        end else begin
          offer(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)), 8'($urandom), id);
          offer(ivr_pkg::CMD_DISPATCH, 8'($urandom), id);
          sent += 2;
        end
      end
    end

    quiet = 1'b0;
    drain_and_settle();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ivr_pkg.sv
hdl/ivr_ctrl.sv
hdl/ivr_dpath.sv
hdl/interrupt_vector_router_core.sv
hdl/ivr_check.sv
tb/testbench.sv
